@@ src/affine_warp_coordinate_generator_core_assert.svh @@
// assertion macros for the affine warp coordinate generator
`ifndef AFFINE_WARP_COORDINATE_GENERATOR_CORE_ASSERT_SVH
`define AFFINE_WARP_COORDINATE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while reset is low
`define AWCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while reset is low
`define AWCG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/awcg_pkg.sv @@
// constants and types shared by the affine warp coordinate generator
package awcg_pkg;

    // geometry and fixed point format
    localparam int MAX_DIM   = 4096;
    localparam int FRAC_BITS = 5;
    localparam int AB_SHIFT  = 10;
    localparam int COORD_W   = 12;
    localparam int COEF_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 10;
    localparam int SRC_W     = 16;

    // rounding bias added before the final shift
    localparam int NEAREST_BIAS = 512;
    localparam int INTERP_BIAS  = (FRAC_BITS < AB_SHIFT) ? (2 ** (AB_SHIFT - 1 - FRAC_BITS)) : 0;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP   = 3'd6;

    // reset value of a unit gain in Q27.20
    localparam logic signed [COEF_W-1:0] COEF_ONE = 48'sd1048576;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [COORD_W-1:0]       t_coord;

endpackage

@@ src/affine_warp_coordinate_generator_core.sv @@
// affine warp coordinate generator: five-stage pipelined source coordinate datapath
//
// Usage:
//   Write the six Q27.20 coefficients and interp_mode through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no pixel is in flight; a write to an unused index is ignored.
//   Present a destination pixel on i_dst_x / i_dst_y with start high; it transfers
//   at every rising edge where start is high and busy is low. busy is always low,
//   so one pixel transfers per clock.
//   The result is on o_src_x / o_src_y / o_frac_index with o_valid high for one
//   cycle, once the pixel has passed stages a to e.
//   Throughput is one pixel per cycle: the four 48x12 products are split into
//   24x12 halves that are registered, then combined, rounded, summed and
//   shifted in stages of their own.
//   The receiver cannot stall; results leave in order of transfer.
//   Reset (synchronous, active low) clears all in-flight pixels and loads the
//   identity matrix in nearest mode.
module affine_warp_coordinate_generator_core
    import awcg_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [COEF_W-1:0]           i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [COORD_W-1:0]          i_dst_x,
    input  logic [COORD_W-1:0]          i_dst_y,
    output logic                        o_valid,
    output logic signed [SRC_W-1:0]     o_src_x,
    output logic signed [SRC_W-1:0]     o_src_y,
    output logic [FRAC_W-1:0]           o_frac_index
);

    localparam int HALF_W = COEF_W / 2;
    localparam int LO_W   = HALF_W + COORD_W;
    localparam int HI_W   = HALF_W + COORD_W + 1;
    localparam int COL_W  = HI_W + HALF_W;
    localparam int TERM_W = COL_W + 1;
    localparam int Q_W    = TERM_W - AB_SHIFT;
    localparam int SUM_W  = 34;
    localparam int INT_W  = SUM_W - AB_SHIFT;

    // configuration registers
    t_coef r_coef_xx, r_coef_xy, r_offset_x, r_coef_yx, r_coef_yy, r_offset_y;
    logic  r_interp_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx     <= COEF_ONE;
            r_coef_xy     <= '0;
            r_offset_x    <= '0;
            r_coef_yx     <= '0;
            r_coef_yy     <= COEF_ONE;
            r_offset_y    <= '0;
            r_interp_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_XX:  r_coef_xx     <= i_cfg_data;
                CFG_COEF_XY:  r_coef_xy     <= i_cfg_data;
                CFG_OFFSET_X: r_offset_x    <= i_cfg_data;
                CFG_COEF_YX:  r_coef_yx     <= i_cfg_data;
                CFG_COEF_YY:  r_coef_yy     <= i_cfg_data;
                CFG_OFFSET_Y: r_offset_y    <= i_cfg_data;
                CFG_INTERP:   r_interp_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // every cycle can take a pixel
    assign busy = 1'b0;

    // round Q.20 to Q.10, ties to even, then clamp to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [TERM_W-1:0] v);
        logic signed [Q_W-1:0] q;
        logic [AB_SHIFT-1:0]   rem;
        logic signed [Q_W:0]   qr;
        logic                  inc;
        q   = v[TERM_W-1:AB_SHIFT];
        rem = v[AB_SHIFT-1:0];
        inc = (rem > 10'd512) || ((rem == 10'd512) && q[0]);
        qr  = $signed({q[Q_W-1], q}) + $signed({{Q_W{1'b0}}, inc});
        if (qr > $signed((Q_W+1)'(64'sd2147483647))) begin
            return 32'sh7fffffff;
        end else if (qr < $signed((Q_W+1)'(-64'sd2147483648))) begin
            return 32'sh80000000;
        end
        return qr[31:0];
    endfunction

    // clamp an integer coordinate to 16 bits
    function automatic logic signed [SRC_W-1:0] sat16(input logic signed [INT_W-1:0] v);
        if (v > $signed(INT_W'(32767))) begin
            return 16'sh7fff;
        end else if (v < $signed(INT_W'(-32768))) begin
            return 16'sh8000;
        end
        return v[SRC_W-1:0];
    endfunction

    // valid bits, one per stage
    logic [3:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[2:0], start && !busy};
            o_valid <= r_vld[3];
        end
    end

    // stage a: clamp coordinates, split products into 24-bit halves
    // product order: xx*cx, xy*cy, yx*cx, yy*cy
    t_coord                   n_cx, n_cy;
    t_coef                    w_coef [4];
    t_coord                   w_dim  [4];
    logic [LO_W-1:0]          n_a_lo [4];
    logic signed [HI_W-1:0]   n_a_hi [4];
    logic [LO_W-1:0]          r_a_lo [4];
    logic signed [HI_W-1:0]   r_a_hi [4];

    always_comb begin
        n_cx = ({4'b0, i_dst_x} > 16'(MAX_DIM - 1)) ? COORD_W'(MAX_DIM - 1) : i_dst_x;
        n_cy = ({4'b0, i_dst_y} > 16'(MAX_DIM - 1)) ? COORD_W'(MAX_DIM - 1) : i_dst_y;
        w_coef[0] = r_coef_xx;
        w_coef[1] = r_coef_xy;
        w_coef[2] = r_coef_yx;
        w_coef[3] = r_coef_yy;
        w_dim[0]  = n_cx;
        w_dim[1]  = n_cy;
        w_dim[2]  = n_cx;
        w_dim[3]  = n_cy;
        for (int k = 0; k < 4; k++) begin
            n_a_lo[k] = LO_W'(w_coef[k][HALF_W-1:0]) * LO_W'(w_dim[k]);
            n_a_hi[k] = HI_W'($signed(w_coef[k][COEF_W-1:HALF_W]))
                      * HI_W'($signed({1'b0, w_dim[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_a_lo[k] <= n_a_lo[k];
            r_a_hi[k] <= n_a_hi[k];
        end
    end

    // stage b: join halves, add translation to the row terms
    // term order: x column, x row, y column, y row
    logic signed [TERM_W-1:0] n_b_term [4];
    logic signed [TERM_W-1:0] r_b_term [4];
    logic signed [TERM_W-1:0] w_full   [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_full[k] = $signed({r_a_hi[k][HI_W-1], r_a_hi[k], {HALF_W{1'b0}}})
                      + $signed({{(TERM_W-LO_W){1'b0}}, r_a_lo[k]});
        end
        n_b_term[0] = w_full[0];
        n_b_term[1] = w_full[1] + $signed({{(TERM_W-COEF_W){r_offset_x[COEF_W-1]}}, r_offset_x});
        n_b_term[2] = w_full[2];
        n_b_term[3] = w_full[3] + $signed({{(TERM_W-COEF_W){r_offset_y[COEF_W-1]}}, r_offset_y});
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_b_term[k] <= n_b_term[k];
        end
    end

    // stage c: round each term and clamp to 32 bits
    logic signed [31:0] r_c_term [4];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_c_term[k] <= round_sat(r_b_term[k]);
        end
    end

    // stage d: sum the two terms and the rounding bias per axis
    logic signed [SUM_W-1:0] n_d_sx, n_d_sy, n_bias;
    logic signed [SUM_W-1:0] r_d_sx, r_d_sy;
    logic                    r_d_mode;

    always_comb begin
        n_bias = r_interp_mode ? SUM_W'(INTERP_BIAS) : SUM_W'(NEAREST_BIAS);
        n_d_sx = SUM_W'(r_c_term[0]) + SUM_W'(r_c_term[1]) + n_bias;
        n_d_sy = SUM_W'(r_c_term[2]) + SUM_W'(r_c_term[3]) + n_bias;
    end

    always_ff @(posedge i_clk) begin
        r_d_sx   <= n_d_sx;
        r_d_sy   <= n_d_sy;
        r_d_mode <= r_interp_mode;
    end

    // stage e: integer part and fraction index into the output register
    logic [FRAC_W-1:0] n_frac;
    logic              r_out_mode;

    always_comb begin
        if (r_d_mode) begin
            n_frac = FRAC_W'({r_d_sy[AB_SHIFT-1 -: FRAC_BITS], r_d_sx[AB_SHIFT-1 -: FRAC_BITS]});
        end else begin
            n_frac = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_src_x      <= sat16(r_d_sx[SUM_W-1:AB_SHIFT]);
        o_src_y      <= sat16(r_d_sy[SUM_W-1:AB_SHIFT]);
        o_frac_index <= n_frac;
        r_out_mode   <= r_d_mode;
    end

    // checks
`include "affine_warp_coordinate_generator_core_assert.svh"

    `AWCG_ASSERT_IMP(a_latency, start && !busy, ##5 o_valid, "result missing five cycles after transfer")
    `AWCG_ASSERT_IMP(a_nearest_frac, o_valid && !r_out_mode, o_frac_index == '0, "fraction set in nearest mode")
    `AWCG_ASSERT_NXT(a_no_phantom, !r_vld[3], !o_valid, "result strobe without a pixel in flight")

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the affine warp coordinate generator core
`timescale 1ns / 1ps

module tb;
    import awcg_pkg::*;

    // register count and the unused index the block must ignore
    localparam int NUM_REGS = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
        CFG_COEF_XX, CFG_COEF_XY, CFG_OFFSET_X, CFG_COEF_YX, CFG_COEF_YY, CFG_OFFSET_Y,
        CFG_INTERP
    };

    // coefficient extremes
    localparam t_coef COEF_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_coef COEF_MIN = 48'sh8000_0000_0000;

    // run control
    localparam int IDLE_GUARD  = 10;
    localparam int STALL_LIMIT = 500;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 128;

    typedef logic signed [SRC_W-1:0] t_src;
    typedef t_coef t_setting [NUM_REGS];

    typedef struct {
        t_src              src_x;
        t_src              src_y;
        logic [FRAC_W-1:0] frac_index;
    } t_src_coord;

    // predicts source coordinates and holds them until the block delivers them
    class warp_scoreboard;
        localparam longint INT32_HI = 64'sh0000_0000_7FFF_FFFF;
        localparam longint INT32_LO = -64'sh0000_0000_8000_0000;
        localparam longint SRC_HI   = 64'sd32767;
        localparam longint SRC_LO   = -64'sd32768;
        localparam longint HALF_LSB = 64'sd1 <<< (AB_SHIFT - 1);

        t_coef      coef_xx, coef_xy, offset_x, coef_yx, coef_yy, offset_y;
        bit         interp;
        t_src_coord awaited[$];
        int         errors;

        function new();
            coef_xx  = COEF_ONE;
            coef_xy  = '0;
            offset_x = '0;
            coef_yx  = '0;
            coef_yy  = COEF_ONE;
            offset_y = '0;
            interp   = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_COEF_XX:  coef_xx  = t_coef'(data);
                CFG_COEF_XY:  coef_xy  = t_coef'(data);
                CFG_OFFSET_X: offset_x = t_coef'(data);
                CFG_COEF_YX:  coef_yx  = t_coef'(data);
                CFG_COEF_YY:  coef_yy  = t_coef'(data);
                CFG_OFFSET_Y: offset_y = t_coef'(data);
                CFG_INTERP:   interp   = data[0];
                default: ;
            endcase
        endfunction

        // q.20 to q.10, nearest with ties to even, clamped to 32 bits
        function longint round_q10(longint v);
            longint q;
            longint rem;
            q   = v >>> AB_SHIFT;
            rem = v - (q <<< AB_SHIFT);
            if (rem > HALF_LSB || (rem == HALF_LSB && q[0]))
                q = q + 1;
            if (q > INT32_HI)
                q = INT32_HI;
            if (q < INT32_LO)
                q = INT32_LO;
            return q;
        endfunction

        function t_src sat16(longint v);
            if (v > SRC_HI)
                v = SRC_HI;
            if (v < SRC_LO)
                v = SRC_LO;
            return t_src'(v);
        endfunction

        function void note_pixel(t_coord x, t_coord y);
            longint     cx, cy, bias, sx, sy, tx, ty, fmask;
            t_src_coord r;
            cx = longint'(x);
            cy = longint'(y);
            if (cx > MAX_DIM - 1)
                cx = MAX_DIM - 1;
            if (cy > MAX_DIM - 1)
                cy = MAX_DIM - 1;
            bias = interp ? longint'(INTERP_BIAS) : longint'(NEAREST_BIAS);
            sx = round_q10(longint'(coef_xx) * cx)
               + round_q10(longint'(coef_xy) * cy + longint'(offset_x)) + bias;
            sy = round_q10(longint'(coef_yx) * cx)
               + round_q10(longint'(coef_yy) * cy + longint'(offset_y)) + bias;
            if (!interp) begin
                r.src_x      = sat16(sx >>> AB_SHIFT);
                r.src_y      = sat16(sy >>> AB_SHIFT);
                r.frac_index = '0;
            end else begin
                tx = sx >>> (AB_SHIFT - FRAC_BITS);
                ty = sy >>> (AB_SHIFT - FRAC_BITS);
                fmask = (64'sd1 <<< FRAC_BITS) - 1;
                r.src_x      = sat16(tx >>> FRAC_BITS);
                r.src_y      = sat16(ty >>> FRAC_BITS);
                r.frac_index = FRAC_W'(((ty & fmask) <<< FRAC_BITS) + (tx & fmask));
            end
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_src sx, t_src sy, logic [FRAC_W-1:0] fi);
            t_src_coord r;
            if (awaited.size() == 0) begin
                $error("result transfer with no pending pixel");
                errors++;
                return;
            end
            r = awaited.pop_front();
            compare_field("src_x", longint'(r.src_x), longint'(sx));
            compare_field("src_y", longint'(r.src_y), longint'(sy));
            compare_field("frac_index", longint'(r.frac_index), longint'(fi));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [COEF_W-1:0]       i_cfg_data;
    logic                    start;
    logic                    busy;
    logic [COORD_W-1:0]      i_dst_x;
    logic [COORD_W-1:0]      i_dst_y;
    logic                    o_valid;
    logic signed [SRC_W-1:0] o_src_x;
    logic signed [SRC_W-1:0] o_src_y;
    logic [FRAC_W-1:0]       o_frac_index;

    warp_scoreboard sb = new();
    int             burst_left = 0;
    int             stall_cycles = 0;

    affine_warp_coordinate_generator_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_dst_x      (i_dst_x),
        .i_dst_y      (i_dst_y),
        .o_valid      (o_valid),
        .o_src_x      (o_src_x),
        .o_src_y      (o_src_y),
        .o_frac_index (o_frac_index)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor: results, register writes and pixel transfers sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_pixel(o_src_x, o_src_y, o_frac_index);
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                sb.note_pixel(i_dst_x, i_dst_y);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // one pixel transfer, with bursts and random gaps between them
    task automatic send_pixel(t_coord x, t_coord y);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_dst_x <= x;
        i_dst_y <= y;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // load all registers starting at a rotating index, optionally poke the unused one
    task automatic load_setting(t_setting s, int rot, bit junk);
        int k;
        int n;
        for (k = 0; k < NUM_REGS; k++) begin
            n = (k + rot) % NUM_REGS;
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_ORDER[n];
            i_cfg_data <= s[n];
            @(posedge i_clk);
        end
        if (junk) begin
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= COEF_W'({$urandom, $urandom});
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic between_phases(t_setting s, int rot, bit junk);
        drain_results();
        repeat (IDLE_GUARD) @(posedge i_clk);
        load_setting(s, rot, junk);
    endtask

    task automatic random_setting(output t_setting s);
        int          k;
        int unsigned pick;
        for (k = 0; k < NUM_REGS; k++) begin
            pick = $urandom_range(0, 9);
            if (REG_ORDER[k] == CFG_INTERP)
                s[k] = t_coef'($urandom_range(0, 1));
            else if (pick <= 5 && (REG_ORDER[k] == CFG_OFFSET_X || REG_ORDER[k] == CFG_OFFSET_Y))
                s[k] = t_coef'($signed($urandom)) <<< 1;
            else if (pick <= 5)
                s[k] = t_coef'(longint'($urandom_range(0, 32'h80_0000)) - 64'sh40_0000);
            else if (pick == 6)
                s[k] = COEF_MAX;
            else if (pick == 7)
                s[k] = COEF_MIN;
            else
                s[k] = t_coef'({$urandom, $urandom});
        end
    endtask

    // stimulus
    initial begin
        t_setting s;
        int       p;
        int       n;
        t_coord   x;
        t_coord   y;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_COEF_XX;
        i_cfg_data <= '0;
        start      <= 1'b0;
        i_dst_x    <= '0;
        i_dst_y    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (IDLE_GUARD) @(posedge i_clk);

        // identity after reset, corner pixels and one inner pixel
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'hAAA, 12'h555);

        // ties in the q.10 rounding, positive and negative, interpolation output
        s = '{48'sd512, 48'sd0, -48'sd512, 48'sd0, 48'sd1536, 48'sd512, 48'sd1};
        between_phases(s, 0, 1'b0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd3, 12'd1);
        send_pixel(12'd2, 12'd2);
        send_pixel(12'd5, 12'd3);

        // coefficient extremes: term clamp at 32 bits and coordinate clamp at 16 bits
        s = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, 48'sd0};
        between_phases(s, 3, 1'b0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd0, 12'd0);

        // fractional gains in interpolation mode, plus a write to the unused index
        s = '{48'sh0C_0000, 48'sh03_0000, -48'sd3158073, -48'sh05_0000, 48'sh14_0000,
              48'sd7341031, 48'sd1};
        between_phases(s, 5, 1'b1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd100, 12'd200);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);

        // mixed extremes in interpolation mode
        s = '{COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 48'sd1};
        between_phases(s, 1, 1'b0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);

        // random settings with random pixels
        for (p = 0; p < RAND_PHASES; p++) begin
            random_setting(s);
            between_phases(s, $urandom_range(0, NUM_REGS - 1), 1'($urandom_range(0, 1)));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // pause for a full drain once in the middle of the stream
                if (p == 4 && n == PHASE_ITEMS / 2)
                    drain_results();
                x = t_coord'($urandom);
                y = t_coord'($urandom);
                if ($urandom_range(0, 15) == 0)
                    x = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 15) == 0)
                    y = $urandom_range(0, 1) ? '1 : '0;
                send_pixel(x, y);
            end
        end

        drain_results();
        repeat (IDLE_GUARD) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/awcg_pkg.sv
src/affine_warp_coordinate_generator_core.sv
dv/tb.sv
